FILE: src/imuss_pkg.sv
// ============================================================================
// imuss_pkg
// Shared types, constants and arithmetic helpers of the IMU sample stamper
// and scaler.
// ============================================================================
package imuss_pkg;

    // Request kinds
    localparam logic REQ_EVENT = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 24;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_SUSPENDED  = 2'd0;
    localparam t_cfg_idx CFG_ACCEL_GAIN = 2'd1;
    localparam t_cfg_idx CFG_GYRO_GAIN  = 2'd2;

    // Register widths and reset values
    localparam int GAIN_W = 24;
    typedef logic [GAIN_W-1:0] t_gain;
    localparam t_gain ACCEL_GAIN_RST = 24'd782872;
    localparam t_gain GYRO_GAIN_RST  = 24'd697450;

    // Ring depth default
    localparam int RING_SLOTS_DEF = 4;

    // Timestamp correction
    localparam logic [31:0] STAMP_ROLL = 32'h0001_0000;

    // New data window
    localparam logic [31:0] DIFF_LIMIT = 32'h7FFF_FFFF;

    // Output widths
    localparam int ACCEL_W = 25;
    localparam int GYRO_W  = 32;
    localparam int TEMP_W  = 16;

    // Temperature: 10000 * t / 33387 + 2100, the division by reciprocal.
    // With |t| <= 2^15 and a 31-bit shift the rounded-up reciprocal is exact.
    localparam longint unsigned TempMul   = 64'd10000;
    localparam longint unsigned TempDiv   = 64'd33387;
    localparam int              TEMP_SH   = 31;
    localparam longint unsigned TEMP_RECIP_L =
        ((TempMul << TEMP_SH) + TempDiv - 64'd1) / TempDiv;
    localparam logic [29:0]     TEMP_RECIP = TEMP_RECIP_L[29:0];
    localparam logic signed [TEMP_W-1:0] TEMP_OFS = 16'sd2100;

    // Accel: v * gain / 2^16, rounded half away from zero, saturated to 25 bits
    function automatic logic signed [ACCEL_W-1:0] accel_scale(
        input logic signed [16:0] v,
        input t_gain              g
    );
        logic [16:0]        mag;
        logic [40:0]        prod;
        logic [24:0]        r;
        logic signed [26:0] s;
        mag  = v[16] ? 17'(-v) : 17'(v);
        prod = 41'(mag) * 41'(g);
        r    = 25'((prod + 41'd32768) >> 16);
        s    = v[16] ? -$signed({2'b00, r}) : $signed({2'b00, r});
        if (s > 27'sd16777215) begin
            accel_scale = 25'sh0FF_FFFF;
        end else if (s < -27'sd16777216) begin
            accel_scale = 25'sh100_0000;
        end else begin
            accel_scale = s[ACCEL_W-1:0];
        end
    endfunction

    // Gyro: v * gain / 2^8, rounded half away from zero, saturated to 32 bits
    function automatic logic signed [GYRO_W-1:0] gyro_scale(
        input logic signed [16:0] v,
        input t_gain              g
    );
        logic [16:0]        mag;
        logic [40:0]        prod;
        logic [32:0]        r;
        logic signed [34:0] s;
        mag  = v[16] ? 17'(-v) : 17'(v);
        prod = 41'(mag) * 41'(g);
        r    = 33'((prod + 41'd128) >> 8);
        s    = v[16] ? -$signed({2'b00, r}) : $signed({2'b00, r});
        if (s > 35'sd2147483647) begin
            gyro_scale = 32'sh7FFF_FFFF;
        end else if (s < -35'sd2147483648) begin
            gyro_scale = 32'sh8000_0000;
        end else begin
            gyro_scale = s[GYRO_W-1:0];
        end
    endfunction

    // Temperature in centidegrees, quotient truncated toward zero
    function automatic logic signed [TEMP_W-1:0] temp_convert(
        input logic signed [15:0] t
    );
        logic [15:0]        mag;
        logic [45:0]        prod;
        logic [13:0]        q;
        logic signed [15:0] sq;
        mag  = t[15] ? 16'(-t) : 16'(t);
        prod = 46'(mag) * 46'(TEMP_RECIP);
        q    = 14'(prod >> TEMP_SH);
        sq   = t[15] ? -$signed({2'b00, q}) : $signed({2'b00, q});
        temp_convert = sq + TEMP_OFS;
    endfunction

endpackage

FILE: src/imu_sample_stamp_and_scale.sv
// ============================================================================
// imu_sample_stamp_and_scale
// Stamps data-ready events into a small ring and scales raw inertial frames.
// ============================================================================
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one word per request.
//   req_type 0 is a data-ready event: the block stamps it into the next ring
//   slot and bumps the event count; it yields no output word. req_type 1 is
//   a sample read: it yields exactly one output word on the output channel
//   (o_out_valid / i_out_ready), valid with the newest event's count, stamp
//   and the frame (scaled, or unscaled in raw mode) when a new event exists and
//   the block is not suspended, else sample_valid 0 with all other fields zero.
//   Path: an accepted read sits in the input register and moves into the
//   output register once that register is empty or its word is being taken;
//   o_out_valid rises as the read enters the output register.
//   Throughput: one word per cycle while the output is not stalled; the six
//   17x24 multiplies and the temperature reciprocal multiply sit in the
//   single stage between the input and output registers.
//   Stall: the output register holds its word while i_out_ready is low; one
//   more read waits in the input register and then blocks the input. Events
//   pass through the input register as long as no read is held there.
//   Reset (synchronous, active low) empties both registers, clears the event
//   counters and loads the default gains, suspended cleared.
//   Configuration writes through i_cfg_we take effect at the next edge; the user
//   must issue them only while the block is idle; the block does not enforce it.
// ============================================================================
module imu_sample_stamp_and_scale #(
    parameter int RING_SLOTS = imuss_pkg::RING_SLOTS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              i_cfg_we,
    input  logic [imuss_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [imuss_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // input channel
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_req_type,
    input  logic [31:0]                       i_now_time,
    input  logic [15:0]                       i_capture_low,
    input  logic                              i_rolled,
    input  logic                              i_raw_mode,
    input  logic signed [15:0]                i_accel_x_raw,
    input  logic signed [15:0]                i_accel_y_raw,
    input  logic signed [15:0]                i_accel_z_raw,
    input  logic signed [15:0]                i_temp_raw,
    input  logic signed [15:0]                i_gyro_x_raw,
    input  logic signed [15:0]                i_gyro_y_raw,
    input  logic signed [15:0]                i_gyro_z_raw,
    // output channel
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_sample_valid,
    output logic [31:0]                       o_sample_count,
    output logic [31:0]                       o_sample_time,
    output logic signed [24:0]                o_accel_x,
    output logic signed [24:0]                o_accel_y,
    output logic signed [24:0]                o_accel_z,
    output logic signed [15:0]                o_temperature,
    output logic signed [31:0]                o_gyro_x,
    output logic signed [31:0]                o_gyro_y,
    output logic signed [31:0]                o_gyro_z
);
    import imuss_pkg::*;

    localparam int SLOT_W = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(RING_SLOTS - 1);

    // Configuration registers
    logic  r_suspended;
    t_gain r_accel_gain;
    t_gain r_gyro_gain;

    // Input register
    logic               r_s1_valid;
    logic               r_s1_req_type;
    logic [31:0]        r_s1_now_time;
    logic [15:0]        r_s1_capture_low;
    logic               r_s1_rolled;
    logic               r_s1_raw_mode;
    logic signed [15:0] r_s1_ax;
    logic signed [15:0] r_s1_ay;
    logic signed [15:0] r_s1_az;
    logic signed [15:0] r_s1_temp;
    logic signed [15:0] r_s1_gx;
    logic signed [15:0] r_s1_gy;
    logic signed [15:0] r_s1_gz;

    // Event state; r_slot is the ring slot of the newest event
    logic [31:0]       r_seen;
    logic [31:0]       r_taken;
    logic [SLOT_W-1:0] r_slot;
    logic [31:0]       r_slot_time [RING_SLOTS];

    // Output register
    logic               r_out_valid;
    logic               r_o_sample_valid;
    logic [31:0]        r_o_sample_count;
    logic [31:0]        r_o_sample_time;
    logic signed [24:0] r_o_accel_x;
    logic signed [24:0] r_o_accel_y;
    logic signed [24:0] r_o_accel_z;
    logic signed [15:0] r_o_temperature;
    logic signed [31:0] r_o_gyro_x;
    logic signed [31:0] r_o_gyro_y;
    logic signed [31:0] r_o_gyro_z;

    // Next values
    logic               s1_go;
    logic               s1_read;
    logic               in_take;
    logic [31:0]        n_seen;
    logic [SLOT_W-1:0]  n_slot;
    logic [31:0]        stamp;
    logic [31:0]        diff;
    logic               fresh_event;
    logic signed [16:0] ax;
    logic signed [16:0] ay;
    logic signed [16:0] az;
    logic signed [16:0] gx;
    logic signed [16:0] gy;
    logic signed [16:0] gz;
    logic               n_sample_valid;
    logic [31:0]        n_sample_count;
    logic [31:0]        n_sample_time;
    logic signed [24:0] n_accel_x;
    logic signed [24:0] n_accel_y;
    logic signed [24:0] n_accel_z;
    logic signed [15:0] n_temperature;
    logic signed [31:0] n_gyro_x;
    logic signed [31:0] n_gyro_y;
    logic signed [31:0] n_gyro_z;

    // Advance the input register: events always drain, reads need room
    assign s1_read    = (r_s1_req_type == REQ_READ);
    assign s1_go      = r_s1_valid && (!s1_read || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_go;
    assign in_take    = i_in_valid && o_in_ready;

    // Stamp the event: upper timer half joined with the capture
    always_comb begin
        stamp = {r_s1_now_time[31:16], r_s1_capture_low};
        if (r_s1_rolled && (r_s1_now_time[15:0] < r_s1_capture_low)) begin
            stamp = stamp - STAMP_ROLL;
        end
    end

    // Advance the ring slot; a wrapped count restarts at slot zero
    assign n_seen = r_seen + 32'd1;
    assign n_slot = ((r_seen == 32'hFFFF_FFFF) || (r_slot == SLOT_LAST))
                  ? '0 : r_slot + 1'b1;

    // New data test
    assign diff        = r_seen - r_taken;
    assign fresh_event = (diff != 32'd0) && (diff < DIFF_LIMIT) && !r_suspended;

    // Widen the axes and negate y and z
    assign ax = {r_s1_ax[15], r_s1_ax};
    assign ay = -{r_s1_ay[15], r_s1_ay};
    assign az = -{r_s1_az[15], r_s1_az};
    assign gx = {r_s1_gx[15], r_s1_gx};
    assign gy = -{r_s1_gy[15], r_s1_gy};
    assign gz = -{r_s1_gz[15], r_s1_gz};

    // Build the result word
    always_comb begin
        n_sample_valid = 1'b0;
        n_sample_count = '0;
        n_sample_time  = '0;
        n_accel_x      = '0;
        n_accel_y      = '0;
        n_accel_z      = '0;
        n_temperature  = '0;
        n_gyro_x       = '0;
        n_gyro_y       = '0;
        n_gyro_z       = '0;
        if (fresh_event) begin
            n_sample_valid = 1'b1;
            // the count is the current event count; the newest slot holds its stamp
            n_sample_count = r_seen;
            n_sample_time  = r_slot_time[r_slot];
            if (r_s1_raw_mode) begin
                n_accel_x     = {{8{ax[16]}}, ax};
                n_accel_y     = {{8{ay[16]}}, ay};
                n_accel_z     = {{8{az[16]}}, az};
                n_temperature = r_s1_temp;
                n_gyro_x      = {{7{gx[16]}}, gx, 8'd0};
                n_gyro_y      = {{7{gy[16]}}, gy, 8'd0};
                n_gyro_z      = {{7{gz[16]}}, gz, 8'd0};
            end else begin
                n_accel_x     = accel_scale(ax, r_accel_gain);
                n_accel_y     = accel_scale(ay, r_accel_gain);
                n_accel_z     = accel_scale(az, r_accel_gain);
                n_temperature = temp_convert(r_s1_temp);
                n_gyro_x      = gyro_scale(gx, r_gyro_gain);
                n_gyro_y      = gyro_scale(gy, r_gyro_gain);
                n_gyro_z      = gyro_scale(gz, r_gyro_gain);
            end
        end
    end

    // Control state: handshake, counters, configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_seen       <= '0;
            r_taken      <= '0;
            r_slot       <= '0;
            r_suspended  <= 1'b0;
            r_accel_gain <= ACCEL_GAIN_RST;
            r_gyro_gain  <= GYRO_GAIN_RST;
        end else begin
            if (in_take) begin
                r_s1_valid <= 1'b1;
            end else if (s1_go) begin
                r_s1_valid <= 1'b0;
            end

            if (s1_go && s1_read) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (s1_go && !s1_read) begin
                r_seen <= n_seen;
                r_slot <= n_slot;
            end else if (s1_go && fresh_event) begin
                r_taken <= r_seen;
            end

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_SUSPENDED:  r_suspended  <= i_cfg_data[0];
                    CFG_ACCEL_GAIN: r_accel_gain <= i_cfg_data;
                    CFG_GYRO_GAIN:  r_gyro_gain  <= i_cfg_data;
                    default:        ;
                endcase
            end
        end
    end

    // Payload: input word, ring, output word
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_req_type    <= i_req_type;
            r_s1_now_time    <= i_now_time;
            r_s1_capture_low <= i_capture_low;
            r_s1_rolled      <= i_rolled;
            r_s1_raw_mode    <= i_raw_mode;
            r_s1_ax          <= i_accel_x_raw;
            r_s1_ay          <= i_accel_y_raw;
            r_s1_az          <= i_accel_z_raw;
            r_s1_temp        <= i_temp_raw;
            r_s1_gx          <= i_gyro_x_raw;
            r_s1_gy          <= i_gyro_y_raw;
            r_s1_gz          <= i_gyro_z_raw;
        end
        if (s1_go && !s1_read) begin
            r_slot_time[n_slot] <= stamp;
        end
        if (s1_go && s1_read) begin
            r_o_sample_valid <= n_sample_valid;
            r_o_sample_count <= n_sample_count;
            r_o_sample_time  <= n_sample_time;
            r_o_accel_x      <= n_accel_x;
            r_o_accel_y      <= n_accel_y;
            r_o_accel_z      <= n_accel_z;
            r_o_temperature  <= n_temperature;
            r_o_gyro_x       <= n_gyro_x;
            r_o_gyro_y       <= n_gyro_y;
            r_o_gyro_z       <= n_gyro_z;
        end
    end

    // Drive the outputs
    assign o_out_valid    = r_out_valid;
    assign o_sample_valid = r_o_sample_valid;
    assign o_sample_count = r_o_sample_count;
    assign o_sample_time  = r_o_sample_time;
    assign o_accel_x      = r_o_accel_x;
    assign o_accel_y      = r_o_accel_y;
    assign o_accel_z      = r_o_accel_z;
    assign o_temperature  = r_o_temperature;
    assign o_gyro_x       = r_o_gyro_x;
    assign o_gyro_y       = r_o_gyro_y;
    assign o_gyro_z       = r_o_gyro_z;

    // A result word only appears after a read left the input register
    a_out_from_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(s1_go && s1_read))
        else $error("output word without a read");

    // A delivered sample marks every seen event as taken
    a_taken_catches_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(s1_go && s1_read && fresh_event) |-> (r_taken == $past(r_seen)))
        else $error("events_taken not caught up after a valid read");

    // Ring slot index stays inside the ring
    a_slot_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot <= SLOT_LAST)
        else $error("ring slot index out of range");

    // Input stalls only behind a blocked read
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_s1_valid && s1_read && r_out_valid && !i_out_ready))
        else $error("input stalled without a blocked read");

endmodule

FILE: test/imu_sample_stamp_and_scale_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// imu_sample_stamp_and_scale_tb
// Drives data-ready events and sample reads through the input channel and
// checks every output word against a cycle-free predictor of the stamp ring,
// the new-data window, suspension, scaling, rounding and temperature
// conversion. Both channels idle at random; gains and suspension change
// between phases while the block is idle.
// ============================================================================
module imu_sample_stamp_and_scale_tb;
    import imuss_pkg::*;

    localparam int     RING        = RING_SLOTS_DEF;
    localparam int     DRAIN_WAIT  = 4;
    localparam int     TEMP_SCALE  = 10000;
    localparam int     TEMP_DIVSR  = 33387;
    localparam int     TEMP_OFFSET = 2100;
    localparam longint ACCEL_MIN   = -64'sd16777216;
    localparam longint ACCEL_MAX   = 64'sd16777215;
    localparam longint GYRO_MIN    = -64'sd2147483648;
    localparam longint GYRO_MAX    = 64'sd2147483647;
    localparam t_gain  GAIN_MAX    = 24'hFF_FFFF;

    typedef struct packed {
        logic               req;
        logic [31:0]        now;
        logic [15:0]        cap;
        logic               rolled;
        logic               raw;
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
        logic signed [15:0] temp;
        logic signed [15:0] gx;
        logic signed [15:0] gy;
        logic signed [15:0] gz;
    } t_imu_req;

    typedef struct packed {
        logic               valid;
        logic [31:0]        count;
        logic [31:0]        stamp;
        logic signed [24:0] ax;
        logic signed [24:0] ay;
        logic signed [24:0] az;
        logic signed [15:0] temp;
        logic signed [31:0] gx;
        logic signed [31:0] gy;
        logic signed [31:0] gz;
    } t_imu_sample;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_cfg_we = 1'b0;
    t_cfg_idx                    i_cfg_idx = CFG_SUSPENDED;
    logic [CFG_DATA_W-1:0]       i_cfg_data = '0;
    logic                        i_in_valid = 1'b0;
    logic                        o_in_ready;
    logic                        i_req_type = REQ_EVENT;
    logic [31:0]                 i_now_time = '0;
    logic [15:0]                 i_capture_low = '0;
    logic                        i_rolled = 1'b0;
    logic                        i_raw_mode = 1'b0;
    logic signed [15:0]          i_accel_x_raw = '0;
    logic signed [15:0]          i_accel_y_raw = '0;
    logic signed [15:0]          i_accel_z_raw = '0;
    logic signed [15:0]          i_temp_raw = '0;
    logic signed [15:0]          i_gyro_x_raw = '0;
    logic signed [15:0]          i_gyro_y_raw = '0;
    logic signed [15:0]          i_gyro_z_raw = '0;
    logic                        o_out_valid;
    logic                        i_out_ready = 1'b0;
    logic                        o_sample_valid;
    logic [31:0]                 o_sample_count;
    logic [31:0]                 o_sample_time;
    logic signed [24:0]          o_accel_x;
    logic signed [24:0]          o_accel_y;
    logic signed [24:0]          o_accel_z;
    logic signed [15:0]          o_temperature;
    logic signed [31:0]          o_gyro_x;
    logic signed [31:0]          o_gyro_y;
    logic signed [31:0]          o_gyro_z;

    // Predictor state: stamp ring, event counters and register shadows
    logic [31:0]  ring_stamp [RING];
    logic [31:0]  ring_count [RING];
    logic [31:0]  events_seen = '0;
    logic [31:0]  events_taken = '0;
    logic         shadow_suspended = 1'b0;
    t_gain        shadow_accel_gain = ACCEL_GAIN_RST;
    t_gain        shadow_gyro_gain = GYRO_GAIN_RST;

    t_imu_sample  expected_samples [$];
    int           mismatches = 0;
    bit           steady_flow = 1'b0;

    imu_sample_stamp_and_scale DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_req_type     (i_req_type),
        .i_now_time     (i_now_time),
        .i_capture_low  (i_capture_low),
        .i_rolled       (i_rolled),
        .i_raw_mode     (i_raw_mode),
        .i_accel_x_raw  (i_accel_x_raw),
        .i_accel_y_raw  (i_accel_y_raw),
        .i_accel_z_raw  (i_accel_z_raw),
        .i_temp_raw     (i_temp_raw),
        .i_gyro_x_raw   (i_gyro_x_raw),
        .i_gyro_y_raw   (i_gyro_y_raw),
        .i_gyro_z_raw   (i_gyro_z_raw),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_sample_valid (o_sample_valid),
        .o_sample_count (o_sample_count),
        .o_sample_time  (o_sample_time),
        .o_accel_x      (o_accel_x),
        .o_accel_y      (o_accel_y),
        .o_accel_z      (o_accel_z),
        .o_temperature  (o_temperature),
        .o_gyro_x       (o_gyro_x),
        .o_gyro_y       (o_gyro_y),
        .o_gyro_z       (o_gyro_z)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        for (int i = 0; i < RING; i++) begin
            ring_stamp[i] = '0;
            ring_count[i] = '0;
        end
    end

    // Stall the output side at random, except during steady stretches
    always @(negedge i_clk) begin
        i_out_ready <= steady_flow || ($urandom_range(99) >= 32);
    end

    // v * gain / 2^shift, rounded half away from zero, clamped to [lo, hi]
    function automatic longint scale_sat(input int v, input longint gain, input int shift,
                                         input longint lo, input longint hi);
        longint mag;
        longint r;
        longint s;
        mag = (v < 0) ? -longint'(v) : longint'(v);
        r = (mag * gain + (longint'(1) << (shift - 1))) >>> shift;
        s = (v < 0) ? -r : r;
        if (s > hi) s = hi;
        if (s < lo) s = lo;
        return s;
    endfunction

    // Update the stamp ring on an event; queue the expected word on a read
    task automatic predict_sample(input t_imu_req w);
        logic [31:0] seq_next;
        logic [31:0] stamp;
        logic [31:0] backlog;
        int          slot;
        int          ax, ay, az, t, gx, gy, gz;
        t_imu_sample s;
        s = '0;
        if (w.req == REQ_EVENT) begin
            seq_next = events_seen + 32'd1;
            stamp = {w.now[31:16], w.cap};
            if (w.rolled && (w.now[15:0] < w.cap)) stamp = stamp - STAMP_ROLL;
            slot = int'(seq_next % RING);
            ring_count[slot] = seq_next;
            ring_stamp[slot] = stamp;
            events_seen = seq_next;
        end else begin
            backlog = events_seen - events_taken;
            if (backlog != 0 && backlog < DIFF_LIMIT && !shadow_suspended) begin
                events_taken = events_seen;
                slot = int'(events_taken % RING);
                ax = $signed(w.ax);
                ay = -$signed(w.ay);
                az = -$signed(w.az);
                t  = $signed(w.temp);
                gx = $signed(w.gx);
                gy = -$signed(w.gy);
                gz = -$signed(w.gz);
                s.valid = 1'b1;
                s.count = ring_count[slot];
                s.stamp = ring_stamp[slot];
                if (w.raw) begin
                    s.ax = 25'(ax);
                    s.ay = 25'(ay);
                    s.az = 25'(az);
                    s.temp = 16'(t);
                    s.gx = 32'(gx * 256);
                    s.gy = 32'(gy * 256);
                    s.gz = 32'(gz * 256);
                end else begin
                    s.ax = 25'(scale_sat(ax, shadow_accel_gain, 16, ACCEL_MIN, ACCEL_MAX));
                    s.ay = 25'(scale_sat(ay, shadow_accel_gain, 16, ACCEL_MIN, ACCEL_MAX));
                    s.az = 25'(scale_sat(az, shadow_accel_gain, 16, ACCEL_MIN, ACCEL_MAX));
                    s.temp = 16'((TEMP_SCALE * t) / TEMP_DIVSR + TEMP_OFFSET);
                    s.gx = 32'(scale_sat(gx, shadow_gyro_gain, 8, GYRO_MIN, GYRO_MAX));
                    s.gy = 32'(scale_sat(gy, shadow_gyro_gain, 8, GYRO_MIN, GYRO_MAX));
                    s.gz = 32'(scale_sat(gz, shadow_gyro_gain, 8, GYRO_MIN, GYRO_MAX));
                end
            end
            expected_samples.push_back(s);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h, got %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Compare each accepted output word with the oldest expectation
    always @(posedge i_clk) begin : check_samples
        t_imu_sample want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_samples.size() == 0) begin
                $display("%0t: unexpected output word, expected none, got valid=%b count=%h",
                         $time, o_sample_valid, o_sample_count);
                mismatches++;
            end else begin
                want = expected_samples.pop_front();
                check_field("sample_valid", 32'(want.valid), 32'(o_sample_valid));
                check_field("sample_count", want.count, o_sample_count);
                check_field("sample_time", want.stamp, o_sample_time);
                check_field("accel_x", 32'(want.ax), 32'(o_accel_x));
                check_field("accel_y", 32'(want.ay), 32'(o_accel_y));
                check_field("accel_z", 32'(want.az), 32'(o_accel_z));
                check_field("temperature", 32'(want.temp), 32'(o_temperature));
                check_field("gyro_x", want.gx, o_gyro_x);
                check_field("gyro_y", want.gy, o_gyro_y);
                check_field("gyro_z", want.gz, o_gyro_z);
            end
        end
    end

    // Offer one word, holding it until accepted, with random gaps before it
    task automatic send_word(input t_imu_req w);
        while (!steady_flow && $urandom_range(99) < 32) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid    <= 1'b1;
        i_req_type    <= w.req;
        i_now_time    <= w.now;
        i_capture_low <= w.cap;
        i_rolled      <= w.rolled;
        i_raw_mode    <= w.raw;
        i_accel_x_raw <= w.ax;
        i_accel_y_raw <= w.ay;
        i_accel_z_raw <= w.az;
        i_temp_raw    <= w.temp;
        i_gyro_x_raw  <= w.gx;
        i_gyro_y_raw  <= w.gy;
        i_gyro_z_raw  <= w.gz;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_sample(w);
    endtask

    // Drop valid, wait for every expected word, then let trailing events settle
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_samples.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            CFG_SUSPENDED:  shadow_suspended = data[0];
            CFG_ACCEL_GAIN: shadow_accel_gain = data;
            CFG_GYRO_GAIN:  shadow_gyro_gain = data;
            default: ;
        endcase
    endtask

    // Raw words lean toward the extremes so sign and saturation paths get hit
    function automatic logic [15:0] pick_raw();
        case ($urandom_range(9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'($urandom_range(0, 4)) - 16'd2;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_imu_req random_word(input logic req);
        t_imu_req w;
        w.req    = req;
        w.now    = $urandom;
        case ($urandom_range(3))
            0: w.cap = w.now[15:0];
            1: w.cap = w.now[15:0] + 16'd1;
            default: w.cap = 16'($urandom);
        endcase
        w.rolled = 1'($urandom_range(1));
        w.raw    = ($urandom_range(3) == 0);
        w.ax     = pick_raw();
        w.ay     = pick_raw();
        w.az     = pick_raw();
        w.temp   = pick_raw();
        w.gx     = pick_raw();
        w.gy     = pick_raw();
        w.gz     = pick_raw();
        return w;
    endfunction

    function automatic t_imu_req event_word(input logic [31:0] now, input logic [15:0] cap,
                                            input logic rolled);
        t_imu_req w;
        w = random_word(REQ_EVENT);
        w.now    = now;
        w.cap    = cap;
        w.rolled = rolled;
        return w;
    endfunction

    function automatic t_imu_req read_word(input logic raw, input logic [15:0] v);
        t_imu_req w;
        w = random_word(REQ_READ);
        w.raw  = raw;
        w.ax   = v;
        w.ay   = v;
        w.az   = v;
        w.temp = v;
        w.gx   = v;
        w.gy   = v;
        w.gz   = v;
        return w;
    endfunction

    // A read with no event behind it returns not valid
    task automatic test_read_before_event();
        send_word(read_word(1'b0, 16'h1234));
    endtask

    // Rollover correction, its wrap below zero, the equal-capture boundary,
    // and the frame extremes including the most negative word
    task automatic test_stamp_rollover();
        send_word(event_word(32'h0001_0005, 16'h0010, 1'b1));
        send_word(read_word(1'b0, 16'h8000));
        send_word(event_word(32'h0000_0005, 16'hFFFF, 1'b1));
        send_word(read_word(1'b1, 16'h8000));
        send_word(event_word(32'h1234_0010, 16'h0010, 1'b1));
        send_word(read_word(1'b0, 16'h7FFF));
    endtask

    // More events than slots: the read returns the newest one
    task automatic test_ring_wrap();
        send_word(event_word(32'hFFFF_FFFF, 16'h0000, 1'b1));
        send_word(event_word(32'h0000_0000, 16'hFFFF, 1'b0));
        send_word(event_word(32'h8000_8000, 16'h7FFF, 1'b0));
        send_word(event_word(32'h0002_0001, 16'h0002, 1'b1));
        send_word(event_word(32'h7FFF_7FFF, 16'h8000, 1'b1));
        send_word(read_word(1'b1, 16'h7FFF));
    endtask

    // Exact halves round away from zero; then the largest and zero gains
    task automatic test_gains_and_rounding();
        t_imu_req w;
        settle();
        write_reg(CFG_ACCEL_GAIN, 24'h00_8000);
        write_reg(CFG_GYRO_GAIN, 24'd128);
        send_word(event_word(32'h0000_1000, 16'h0800, 1'b0));
        w = read_word(1'b0, 16'h0001);
        w.az   = 16'hFFFF;
        w.gy   = 16'hFFFF;
        w.temp = 16'hFFFF;
        send_word(w);
        settle();
        write_reg(CFG_ACCEL_GAIN, GAIN_MAX);
        write_reg(CFG_GYRO_GAIN, GAIN_MAX);
        send_word(event_word(32'h0003_0000, 16'h0001, 1'b1));
        send_word(read_word(1'b0, 16'h8000));
        settle();
        write_reg(CFG_ACCEL_GAIN, 24'd0);
        write_reg(CFG_GYRO_GAIN, 24'd0);
        send_word(event_word(32'h0004_0000, 16'h0000, 1'b0));
        send_word(random_word(REQ_READ));
        settle();
    endtask

    // Suspension holds the event back; it is returned once resumed, then nothing
    task automatic test_suspend();
        write_reg(CFG_SUSPENDED, 24'd1);
        send_word(event_word(32'h0005_0100, 16'h0200, 1'b1));
        send_word(read_word(1'b0, 16'h0100));
        settle();
        write_reg(CFG_SUSPENDED, 24'd0);
        send_word(read_word(1'b0, 16'h0100));
        send_word(read_word(1'b1, 16'hFF00));
    endtask

    // Mostly bursts of events closed by a read, some loose words between
    task automatic run_traffic(input int count);
        int sent;
        int burst;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(99) < 75) begin
                burst = $urandom_range(1, 6);
                repeat (burst) send_word(random_word(REQ_EVENT));
                send_word(random_word(REQ_READ));
                sent += burst + 1;
                if ($urandom_range(3) == 0) begin
                    send_word(random_word(REQ_READ));
                    sent++;
                end
            end else begin
                send_word(random_word(1'($urandom_range(1))));
                sent++;
            end
        end
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 6; phase++) begin
            settle();
            case (phase)
                0: begin
                    write_reg(CFG_ACCEL_GAIN, ACCEL_GAIN_RST);
                    write_reg(CFG_GYRO_GAIN, GYRO_GAIN_RST);
                end
                1: begin
                    write_reg(CFG_ACCEL_GAIN, 24'd0);
                    write_reg(CFG_GYRO_GAIN, GAIN_MAX);
                end
                2: begin
                    write_reg(CFG_ACCEL_GAIN, GAIN_MAX);
                    write_reg(CFG_GYRO_GAIN, 24'd0);
                end
                default: begin
                    write_reg(CFG_ACCEL_GAIN, CFG_DATA_W'($urandom_range(0, GAIN_MAX)));
                    write_reg(CFG_GYRO_GAIN, CFG_DATA_W'($urandom_range(0, GAIN_MAX)));
                end
            endcase
            // Run one phase back to back on both sides
            steady_flow = (phase == 3);
            if (phase == 4) begin
                write_reg(CFG_SUSPENDED, 24'd1);
                run_traffic(20);
                settle();
                write_reg(CFG_SUSPENDED, 24'd0);
                run_traffic(80);
            end else begin
                run_traffic(100);
            end
        end
        steady_flow = 1'b0;
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_read_before_event();
        test_stamp_rollover();
        test_ring_wrap();
        test_gains_and_rounding();
        test_suspend();
        test_random_traffic();
        settle();
        if (mismatches == 0 && expected_samples.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Hard stop far beyond the slowest correct run
    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
